@@ rtl/gradient_color_map_assert.svh @@
// assertion macros for the gradient color map
`ifndef GRADIENT_COLOR_MAP_ASSERT_SVH
`define GRADIENT_COLOR_MAP_ASSERT_SVH
`ifndef SYNTHESIS
`define GCM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCM_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GCM_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCM_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/gcm_pkg.sv @@
// shared types and constants for the gradient color map
`default_nettype none
package gcm_pkg;
	localparam int MAX_STOPS  = 7;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int STOP_W     = 49;
	localparam int POS_W      = 17;
	localparam int POS_LSB    = 32;
	localparam int VAL_W      = 18;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 4;
	localparam int FRAC_W     = 16;
	localparam int QUOT_W     = FRAC_W + 1;
	localparam int DIV_CNT_W  = 5;
	localparam int PROD_W     = 27;

	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 4'd1;

	localparam logic signed [VAL_W-1:0] VAL_ONE  = 18'sd65536;
	localparam logic [CHAN_W-1:0]       CHAN_MAX = 8'hff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_RES
	} state_t;

	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] num;
		logic [POS_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	// channel 0 red, 1 green, 2 blue, 3 alpha
	function automatic logic [CHAN_W-1:0] chan_of(input logic [STOP_W-1:0] s,
			input logic [1:0] k);
		logic [CHAN_W-1:0] c;
		unique case (k)
			2'd0: c = s[31:24];
			2'd1: c = s[23:16];
			2'd2: c = s[15:8];
			default: c = s[7:0];
		endcase
		return c;
	endfunction

	function automatic logic [POS_W-1:0] pos_of(input logic [STOP_W-1:0] s);
		return s[POS_LSB +: POS_W];
	endfunction
endpackage
`default_nettype wire

@@ rtl/gcm_cfg.sv @@
// stop count and gradient stop registers with one read port
`default_nettype none
module gcm_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [gcm_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [gcm_pkg::STOP_W-1:0]      wr_data,
	input  wire logic [gcm_pkg::CNT_W-1:0]       rd_idx,
	output logic      [gcm_pkg::STOP_W-1:0]      rd_stop,
	output logic      [gcm_pkg::CNT_W-1:0]       stop_count
);
	logic [gcm_pkg::CNT_W-1:0]     count_q;
	logic [gcm_pkg::STOP_W-1:0]    stop_q [gcm_pkg::MAX_STOPS];
	logic [gcm_pkg::CFG_IDX_W-1:0] widx;
	logic                          stop_sel;

	assign widx     = wr_index - gcm_pkg::REG_STOP_FIRST;
	assign stop_sel = (wr_index >= gcm_pkg::REG_STOP_FIRST) &&
		(widx < gcm_pkg::CFG_IDX_W'(gcm_pkg::MAX_STOPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < gcm_pkg::MAX_STOPS; i++) begin
				stop_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == gcm_pkg::REG_STOP_COUNT) begin
				count_q <= wr_data[gcm_pkg::CNT_W-1:0];
			end else if (stop_sel) begin
				stop_q[widx[gcm_pkg::CNT_W-1:0]] <= wr_data;
			end
		end
	end

	assign rd_stop    = stop_q[rd_idx];
	assign stop_count = count_q;
endmodule
`default_nettype wire

@@ rtl/gcm_div.sv @@
// restoring divider for the rounded interpolation fraction
`default_nettype none
module gcm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gcm_pkg::div_req_t req,
	output gcm_pkg::div_rsp_t      rsp
);
	logic                              busy_q;
	logic                              done_q;
	logic [gcm_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [gcm_pkg::POS_W-1:0]         r_q;
	logic [gcm_pkg::POS_W-1:0]         d_q;
	logic [gcm_pkg::FRAC_W-1:0]        q_q;
	logic [gcm_pkg::QUOT_W-1:0]        quot_q;
	logic [gcm_pkg::POS_W:0]           r2;
	logic [gcm_pkg::POS_W:0]           r2_sub;
	logic                              ge;
	logic                              rnd;

	assign r2     = {r_q, 1'b0};
	assign ge     = r2 >= {1'b0, d_q};
	assign r2_sub = r2 - {1'b0, d_q};
	// round half up: remainder at least half the divisor
	assign rnd    = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= gcm_pkg::DIV_CNT_W'(gcm_pkg::FRAC_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= req.num;
			d_q <= req.den;
			q_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				r_q <= ge ? r2_sub[gcm_pkg::POS_W-1:0] : r2[gcm_pkg::POS_W-1:0];
				q_q <= {q_q[gcm_pkg::FRAC_W-2:0], ge};
			end else begin
				quot_q <= {1'b0, q_q} + gcm_pkg::QUOT_W'(rnd);
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule
`default_nettype wire

@@ rtl/gradient_color_map.sv @@
// gradient color map top level: stop scan, fraction divide, channel blend
//
//  channel | handshake            | payload
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | value
//  out     | out_valid/out_ready  | red, green, blue, alpha, matched
//
// interpolated word: the scan runs up to the bracketing pair, then the fraction divide and the blend:
// one stop per cycle in the scan, then the shared divider, then the multiplier
// a value of 1.0 or more or no pair found scans all n stops, no stops in use skips the scan
// reset clears stop count and all stops to zero
// next word is taken once the result has moved into the output register
// cfg writes are always taken; that they apply while idle is up to the user, the block does not enforce it
`default_nettype none
`include "gradient_color_map_assert.svh"
module gradient_color_map (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic        [gcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [gcm_pkg::STOP_W-1:0]    cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [gcm_pkg::VAL_W-1:0]     value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic             [gcm_pkg::CHAN_W-1:0]    red,
	output logic             [gcm_pkg::CHAN_W-1:0]    green,
	output logic             [gcm_pkg::CHAN_W-1:0]    blue,
	output logic             [gcm_pkg::CHAN_W-1:0]    alpha,
	output logic                                      matched
);
	gcm_pkg::state_t state_q, state_d;

	logic [gcm_pkg::STOP_W-1:0]              rd_stop;
	logic [gcm_pkg::CNT_W-1:0]               stop_count;
	logic [gcm_pkg::CNT_W-1:0]               n_in;
	logic [gcm_pkg::CNT_W-1:0]               n_q;
	logic [gcm_pkg::CNT_W-1:0]               idx_q;
	logic [gcm_pkg::CNT_W-1:0]               idx_nxt;
	logic signed [gcm_pkg::VAL_W-1:0]        v_q;
	logic                                    ge1_q;
	logic                                    have_lo_q;
	logic                                    have_hi_q;
	logic [gcm_pkg::STOP_W-1:0]              lo_stop_q;
	logic [gcm_pkg::STOP_W-1:0]              hi_stop_q;
	logic [gcm_pkg::NUM_CHAN-1:0][gcm_pkg::CHAN_W-1:0] res_col_q;
	logic                                    res_match_q;
	logic [gcm_pkg::QUOT_W-1:0]              f_q;
	logic [gcm_pkg::CNT_W-1:0]               cnt_q;
	logic [gcm_pkg::CNT_W-1:0]               cnt_m1;
	logic signed [gcm_pkg::PROD_W-1:0]       prod_q;
	logic signed [gcm_pkg::PROD_W-1:0]       prod_d;
	logic signed [gcm_pkg::PROD_W-1:0]       blend_sum;
	logic [gcm_pkg::CHAN_W-1:0]              a_q;
	logic [gcm_pkg::CHAN_W-1:0]              chan_a;
	logic [gcm_pkg::CHAN_W-1:0]              chan_b;
	logic signed [gcm_pkg::CHAN_W:0]         chan_diff;
	logic signed [gcm_pkg::QUOT_W:0]         f_s;
	logic [gcm_pkg::POS_W-1:0]               lo_pos;
	logic [gcm_pkg::POS_W-1:0]               hi_pos;
	logic signed [gcm_pkg::VAL_W:0]          num_full;
	logic                                    in_fire;
	logic                                    le;
	logic                                    ok_next;
	logic                                    last_stop;
	logic                                    mul_last;
	logic                                    res_load;
	logic                                    out_valid_q;
	logic [gcm_pkg::NUM_CHAN-1:0][gcm_pkg::CHAN_W-1:0] out_col_q;
	logic                                    out_match_q;
	gcm_pkg::div_req_t                       div_req;
	gcm_pkg::div_rsp_t                       div_rsp;

	gcm_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid && cfg_ready),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.rd_idx     (idx_q),
		.rd_stop    (rd_stop),
		.stop_count (stop_count)
	);

	gcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == gcm_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign n_in      = (stop_count > gcm_pkg::CNT_W'(gcm_pkg::MAX_STOPS)) ?
		gcm_pkg::CNT_W'(gcm_pkg::MAX_STOPS) : stop_count;
	assign idx_nxt   = idx_q + 1'b1;
	assign last_stop = (idx_nxt == n_q);

	// stop at or below the value
	assign le      = $signed({2'b00, gcm_pkg::pos_of(rd_stop)}) <= $signed({v_q[gcm_pkg::VAL_W-1], v_q});
	assign ok_next = (have_lo_q || le) && (have_hi_q || !le);

	assign lo_pos   = gcm_pkg::pos_of(lo_stop_q);
	assign hi_pos   = gcm_pkg::pos_of(hi_stop_q);
	assign num_full = $signed({v_q[gcm_pkg::VAL_W-1], v_q}) - $signed({2'b00, lo_pos});

	assign div_req.start = (state_q == gcm_pkg::ST_PREP);
	assign div_req.num   = num_full[gcm_pkg::POS_W-1:0];
	assign div_req.den   = hi_pos - lo_pos;

	// shared blend multiplier, one channel a cycle
	assign mul_last  = (cnt_q == gcm_pkg::CNT_W'(gcm_pkg::NUM_CHAN));
	assign cnt_m1    = cnt_q - 1'b1;
	assign chan_a    = gcm_pkg::chan_of(lo_stop_q, cnt_q[1:0]);
	assign chan_b    = gcm_pkg::chan_of(hi_stop_q, cnt_q[1:0]);
	assign chan_diff = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
	assign f_s       = $signed({1'b0, f_q});
	assign prod_d    = gcm_pkg::PROD_W'(chan_diff) * gcm_pkg::PROD_W'(f_s);
	assign blend_sum = $signed({3'b000, a_q, 16'h0000}) + prod_q + 27'sd32768;

	assign res_load = (state_q == gcm_pkg::ST_RES) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gcm_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = (n_in == '0) ? gcm_pkg::ST_RES : gcm_pkg::ST_SCAN;
				end
			end
			gcm_pkg::ST_SCAN: begin
				if (ge1_q) begin
					if (last_stop) begin
						state_d = gcm_pkg::ST_RES;
					end
				end else if (ok_next) begin
					state_d = gcm_pkg::ST_PREP;
				end else if (last_stop) begin
					state_d = gcm_pkg::ST_RES;
				end
			end
			gcm_pkg::ST_PREP: begin
				state_d = gcm_pkg::ST_DIV;
			end
			gcm_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = gcm_pkg::ST_MUL;
				end
			end
			gcm_pkg::ST_MUL: begin
				if (mul_last) begin
					state_d = gcm_pkg::ST_RES;
				end
			end
			gcm_pkg::ST_RES: begin
				if (res_load) begin
					state_d = gcm_pkg::ST_IDLE;
				end
			end
			default: state_d = gcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			ge1_q     <= 1'b0;
			have_lo_q <= 1'b0;
			have_hi_q <= 1'b0;
		end else begin
			unique case (state_q)
				gcm_pkg::ST_IDLE: begin
					if (in_fire) begin
						n_q       <= n_in;
						idx_q     <= '0;
						ge1_q     <= (value >= gcm_pkg::VAL_ONE);
						have_lo_q <= 1'b0;
						have_hi_q <= 1'b0;
					end
				end
				gcm_pkg::ST_SCAN: begin
					idx_q <= idx_nxt;
					if (le) begin
						have_lo_q <= 1'b1;
					end else begin
						have_hi_q <= 1'b1;
					end
				end
				gcm_pkg::ST_DIV: begin
					cnt_q <= '0;
				end
				gcm_pkg::ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gcm_pkg::ST_IDLE: begin
				if (in_fire) begin
					v_q         <= value;
					res_col_q   <= {gcm_pkg::CHAN_MAX, 8'h00, 8'h00, 8'h00};
					res_match_q <= 1'b0;
				end
			end
			gcm_pkg::ST_SCAN: begin
				if (le) begin
					lo_stop_q <= rd_stop;
				end else begin
					hi_stop_q <= rd_stop;
				end
				if (ge1_q && last_stop) begin
					for (int k = 0; k < gcm_pkg::NUM_CHAN; k++) begin
						res_col_q[k] <= gcm_pkg::chan_of(rd_stop, 2'(k));
					end
					res_match_q <= 1'b1;
				end
			end
			gcm_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					f_q <= div_rsp.quot;
				end
			end
			gcm_pkg::ST_MUL: begin
				if (!mul_last) begin
					prod_q <= prod_d;
					a_q    <= chan_a;
				end
				if (cnt_q != '0) begin
					res_col_q[cnt_m1[1:0]] <= blend_sum[23:16];
				end
				if (mul_last) begin
					res_match_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_col_q   <= res_col_q;
			out_match_q <= res_match_q;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = out_col_q[0];
	assign green     = out_col_q[1];
	assign blue      = out_col_q[2];
	assign alpha     = out_col_q[3];
	assign matched   = out_match_q;

	`GCM_NEVER(a_idle_div_busy, clk, arst_n, in_ready && div_rsp.busy, "divider busy while idle")
	`GCM_ASSERT(a_done_in_div, clk, arst_n, div_rsp.done |-> (state_q == gcm_pkg::ST_DIV), "divider done outside divide")
	`GCM_ASSERT(a_mul_pair, clk, arst_n, (state_q == gcm_pkg::ST_MUL) |-> (have_lo_q && have_hi_q), "blend without bracketing pair")
	`GCM_ASSERT(a_frac_range, clk, arst_n, div_rsp.done |-> (div_rsp.quot <= 17'd65536), "fraction above one")
endmodule
`default_nettype wire
